@@ rtl/core/weighted_time_slot_scheduler_top_assert.svh @@
// assertion macros for the weighted time slot scheduler
// expects i_clk and i_rst_n in the scope of every use
`ifndef WEIGHTED_TIME_SLOT_SCHEDULER_TOP_ASSERT_SVH
`define WEIGHTED_TIME_SLOT_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define WTS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WTS_ASSERT(label, expr, msg)

`define WTS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/wtss_pkg.sv @@
// shared types and constants of the weighted time slot scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wtss_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int DATA_W      = 16;
    localparam int ENTRY_W     = 2 * DATA_W;
    localparam int TICK_STEPS  = DATA_W + 1;
    localparam int BIT_W       = $clog2(TICK_STEPS + 1);

    localparam logic [DATA_W-1:0] WEIGHT_LIMIT_RST  = 16'd100;
    localparam logic [DATA_W-1:0] CLOCK_MODULUS_RST = 16'd100;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_WEIGHT_LIMIT  = 1'b0,
        CFG_CLOCK_MODULUS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RES_OK    = 2'd0,
        RES_ERR   = 2'd1,
        RES_MISS  = 2'd2,
        RES_CHECK = 2'd3
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     idx_inc;
        logic     base_cap;
        logic     add_commit;
        logic     shift_wr;
        logic     rem_commit;
        logic     tick_step;
        logic     tick_commit;
        logic     res_en;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic at_end;
        logic hit;
        logic add_ok;
        logic tick_ready;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/wtss_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module wtss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/wtss_ctrl.sv @@
// controller state machine of the weighted time slot scheduler
// depends on wtss_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "weighted_time_slot_scheduler_top_assert.svh"

module wtss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    input  wire logic [1:0]     i_s_tuser,
    output logic                o_s_tready,
    input  wire wtss_pkg::t_stat i_stat,
    output wtss_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_TICK
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = (wtss_pkg::t_op'(i_s_tuser) == wtss_pkg::OP_TICK) ? S_TICK : S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (i_stat.at_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.res_en = 1'b1;
                        n_state = S_IDLE;
                        unique case (i_stat.op)
                            wtss_pkg::OP_ADD: begin
                                if (i_stat.add_ok) begin
                                    o_cmd.add_commit = 1'b1;
                                    o_cmd.res_sel    = wtss_pkg::RES_OK;
                                end else begin
                                    o_cmd.res_sel    = wtss_pkg::RES_ERR;
                                end
                            end
                            wtss_pkg::OP_REMOVE: o_cmd.res_sel = wtss_pkg::RES_ERR;
                            wtss_pkg::OP_CHECK:  o_cmd.res_sel = wtss_pkg::RES_MISS;
                            wtss_pkg::OP_TICK:   o_cmd.res_sel = wtss_pkg::RES_OK;
                        endcase
                    end
                end else if (i_stat.hit) begin
                    unique case (i_stat.op)
                        wtss_pkg::OP_REMOVE: begin
                            o_cmd.idx_inc = 1'b1;
                            n_state = S_SHIFT;
                        end
                        wtss_pkg::OP_CHECK: begin
                            if (i_stat.out_free) begin
                                o_cmd.res_en  = 1'b1;
                                o_cmd.res_sel = wtss_pkg::RES_CHECK;
                                n_state = S_IDLE;
                            end
                        end
                        wtss_pkg::OP_ADD, wtss_pkg::OP_TICK: begin
                            if (i_stat.out_free) begin
                                o_cmd.res_en  = 1'b1;
                                o_cmd.res_sel = wtss_pkg::RES_ERR;
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end else begin
                    o_cmd.base_cap = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.at_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.rem_commit = 1'b1;
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_sel    = wtss_pkg::RES_OK;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.shift_wr = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_TICK: begin
                if (i_stat.tick_ready) begin
                    if (i_stat.out_free) begin
                        o_cmd.tick_commit = 1'b1;
                        o_cmd.res_en      = 1'b1;
                        o_cmd.res_sel     = wtss_pkg::RES_OK;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.tick_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `WTS_ASSERT_NEXT(a_accept_leaves_idle, (r_state == S_IDLE) && i_s_tvalid, r_state != S_IDLE, "accepted transaction did not start work")
    `WTS_ASSERT(a_shift_only_on_remove, (r_state == S_SHIFT) |-> (i_stat.op == wtss_pkg::OP_REMOVE), "table shift outside a remove")

endmodule

`default_nettype wire

@@ rtl/core/wtss_dp.sv @@
// datapath of the weighted time slot scheduler: table ram, counters, slot clock,
// bit-serial remainder unit, configuration and result registers; depends on wtss_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "weighted_time_slot_scheduler_top_assert.svh"

module wtss_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire wtss_pkg::t_cmd              i_cmd,
    output wtss_pkg::t_stat                  o_stat,
    input  wire logic [31:0]                 i_s_tdata,
    input  wire logic [1:0]                  i_s_tuser,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_addr,
    input  wire logic [wtss_pkg::DATA_W-1:0] i_cfg_data,
    input  wire logic                        i_m_tready,
    output logic                             o_m_tvalid,
    output logic [23:0]                      o_m_tdata
);

    localparam int DW = wtss_pkg::DATA_W;
    localparam int CW = wtss_pkg::CNT_W;
    localparam int IW = wtss_pkg::IDX_W;
    localparam int BW = wtss_pkg::BIT_W;

    wtss_pkg::t_op   r_op;
    logic [DW-1:0]   r_id;
    logic [DW-1:0]   r_w;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   n_idx;
    logic [CW-1:0]   r_count;
    logic [DW-1:0]   r_base;
    logic [DW-1:0]   r_wtotal;
    logic [DW-1:0]   r_clock;
    logic [DW-1:0]   r_limit;
    logic [DW-1:0]   r_mod;
    logic [DW:0]     r_div;
    logic [DW:0]     r_rem;
    logic [BW-1:0]   r_bit;
    logic            r_m_valid;
    wtss_pkg::t_status r_m_status;
    logic [DW-1:0]   r_m_clock;

    logic [wtss_pkg::ENTRY_W-1:0] rd_data;
    logic [wtss_pkg::ENTRY_W-1:0] wr_data;
    logic [IW-1:0]                wr_addr;
    logic                         wr_en;
    logic [DW-1:0]                rd_id;
    logic [DW-1:0]                rd_total;
    logic [CW-1:0]                idx_prev;
    logic [DW:0]                  add_sum;
    logic [DW:0]                  wsum;
    logic [DW:0]                  rem_shift;
    logic [DW:0]                  rem_next;
    logic [DW-1:0]                shift_total;
    logic [DW-1:0]                tick_val;
    logic [DW:0]                  check_hi;
    logic                         in_slot;
    logic                         mod_zero;
    logic                         out_free;
    wtss_pkg::t_status            res_status;

    assign rd_id       = rd_data[wtss_pkg::ENTRY_W-1:DW];
    assign rd_total    = rd_data[DW-1:0];
    assign idx_prev    = r_idx - CW'(1);
    assign add_sum     = {1'b0, r_base} + {1'b0, r_w};
    assign wsum        = {1'b0, r_wtotal} + {1'b0, r_w};
    assign shift_total = (rd_total > r_w) ? (rd_total - r_w) : '0;
    assign rem_shift   = {r_rem[DW-1:0], r_div[DW]};
    assign rem_next    = (rem_shift >= {1'b0, r_mod}) ? (rem_shift - {1'b0, r_mod}) : rem_shift;
    assign mod_zero    = (r_mod == '0);
    assign tick_val    = mod_zero ? r_div[DW-1:0] : r_rem[DW-1:0];
    assign check_hi    = {1'b0, r_clock} + {1'b0, r_w};
    assign in_slot     = ({1'b0, rd_total} <= check_hi) && (r_clock < rd_total);
    assign out_free    = !r_m_valid || i_m_tready;

    always_comb begin
        priority if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign wr_en   = i_cmd.add_commit || i_cmd.shift_wr;
    assign wr_addr = i_cmd.add_commit ? r_count[IW-1:0] : idx_prev[IW-1:0];
    assign wr_data = i_cmd.add_commit ? {r_id, add_sum[DW-1:0]} : {rd_id, shift_total};

    wtss_ram #(
        .WIDTH (wtss_pkg::ENTRY_W),
        .DEPTH (wtss_pkg::MAX_CLIENTS),
        .ADDR_W(IW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(n_idx[IW-1:0]),
        .o_rd_data(rd_data)
    );

    always_comb begin
        unique case (i_cmd.res_sel)
            wtss_pkg::RES_OK:    res_status = wtss_pkg::ST_OK;
            wtss_pkg::RES_ERR:   res_status = wtss_pkg::ST_ERR;
            wtss_pkg::RES_MISS:  res_status = wtss_pkg::ST_MISS;
            wtss_pkg::RES_CHECK: res_status = in_slot ? wtss_pkg::ST_OK : wtss_pkg::ST_MISS;
        endcase
    end

    assign o_stat.op         = r_op;
    assign o_stat.at_end     = (r_idx == r_count);
    assign o_stat.hit        = (r_idx != r_count) && (rd_id == r_id);
    assign o_stat.add_ok     = (r_count < CW'(wtss_pkg::MAX_CLIENTS)) &&
                               (add_sum <= {1'b0, r_limit});
    assign o_stat.tick_ready = mod_zero || (r_bit == BW'(wtss_pkg::TICK_STEPS));
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_wtotal  <= '0;
            r_clock   <= '0;
            r_limit   <= wtss_pkg::WEIGHT_LIMIT_RST;
            r_mod     <= wtss_pkg::CLOCK_MODULUS_RST;
            r_bit     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cfg_valid) begin
                unique case (wtss_pkg::t_cfg_idx'(i_cfg_addr))
                    wtss_pkg::CFG_WEIGHT_LIMIT:  r_limit <= i_cfg_data;
                    wtss_pkg::CFG_CLOCK_MODULUS: r_mod   <= i_cfg_data;
                endcase
            end
            if (i_cmd.load) begin
                r_bit <= '0;
            end else if (i_cmd.tick_step) begin
                r_bit <= r_bit + BW'(1);
            end
            if (i_cmd.add_commit) begin
                r_count  <= r_count + CW'(1);
                r_wtotal <= wsum[DW] ? '1 : wsum[DW-1:0];
            end else if (i_cmd.rem_commit) begin
                r_count  <= r_count - CW'(1);
                r_wtotal <= (r_wtotal > r_w) ? (r_wtotal - r_w) : '0;
            end
            if (i_cmd.tick_commit) begin
                r_clock <= tick_val;
            end
            if (i_cmd.res_en) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= wtss_pkg::t_op'(i_s_tuser);
            r_id   <= i_s_tdata[DW-1:0];
            r_w    <= i_s_tdata[2*DW-1:DW];
            r_base <= '0;
            r_div  <= {1'b0, r_clock} + {{DW{1'b0}}, 1'b1};
            r_rem  <= '0;
        end else begin
            if (i_cmd.base_cap) begin
                r_base <= rd_total;
            end
            if (i_cmd.tick_step) begin
                r_rem <= rem_next;
                r_div <= {r_div[DW-1:0], 1'b0};
            end
        end
        if (i_cmd.res_en) begin
            r_m_status <= res_status;
            r_m_clock  <= i_cmd.tick_commit ? tick_val : r_clock;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_m_clock, r_m_status};

    `WTS_ASSERT(a_count_in_range, r_count <= CW'(wtss_pkg::MAX_CLIENTS), "entry count above table depth")
    `WTS_ASSERT(a_add_has_room, i_cmd.add_commit |-> (r_count < CW'(wtss_pkg::MAX_CLIENTS)), "append into a full table")
    `WTS_ASSERT(a_remove_not_empty, i_cmd.rem_commit |-> (r_count != '0), "remove from an empty table")
    `WTS_ASSERT(a_result_not_lost, i_cmd.res_en |-> out_free, "result written over a pending result")

endmodule

`default_nettype wire

@@ rtl/core/weighted_time_slot_scheduler_top.sv @@
// top level of the weighted time slot scheduler
// depends on wtss_pkg, wtss_ctrl, wtss_dp and wtss_ram
`timescale 1ns / 1ps
`default_nettype none

// One operation is taken at a time and gives exactly one result. An add, remove
// or check walks the client table through its single read port, one entry per
// cycle, and ends early when a check or a duplicate add hits; a remove moves the
// later entries down within the same walk. A tick runs the 17-step bit-serial
// remainder unit, which is skipped when the clock modulus is zero. A new operation
// is accepted once the previous one has finished, even while its result still
// waits in the output register.

module weighted_time_slot_scheduler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // owner_id [15:0], weight [31:16]
    input  wire logic [1:0]  i_s_tuser,   // operation [1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // status [1:0], slot_clock [17:2], zero [23:18]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    wtss_pkg::t_cmd  cmd;
    wtss_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    wtss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tuser (i_s_tuser),
        .o_s_tready(o_s_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    wtss_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
